FILE: rtl/tlvd_pkg.sv
// ----------------------------------------------------------------------------
// tlvd_pkg
// shared types and constants of the type-length packet deframer
// ----------------------------------------------------------------------------
package tlvd_pkg;

    localparam int TYPE_COUNT_DEF = 64;
    localparam int MASK_W         = 64;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 4;

    localparam logic [MASK_W-1:0] RESET_MASK = 64'h0000_0000_0000_0003;

    // register index, taken from paddr[3]
    localparam logic REG_ACCEPT_MASK = 1'b0;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_HDR3    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_ERROR   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [15:0] byte_offset;
        logic [7:0]  byte_value;
        logic [15:0] payload_length;
        logic [15:0] pkt_type;
        t_kind       kind;
        logic        last;
    } t_result;

endpackage

FILE: rtl/type_length_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// type_length_packet_deframer_core
// splits a byte stream into type-length packets with a type filter
// ----------------------------------------------------------------------------
// One byte is taken per clock with no bubbles while the master side keeps
// up. Each request is handled in the cycle it is accepted by the
// header/payload logic and its result lands in a single output register,
// so it is presented in the cycle after. A result that waits on the master
// side holds off every further byte, whether or not that byte produces a
// result, until it is taken; the register refills in the same cycle it
// drains. The first three header bytes and every byte after a protocol
// error produce no result; an error holds until reset. The accept mask sits
// at byte address 0 and is used at the next header check.
module type_length_packet_deframer_core #(
    parameter int TYPE_COUNT = tlvd_pkg::TYPE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] data_byte
    // master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [15:0] pkt_type, [31:16] payload_length, [39:32] byte_value,
    // [55:40] byte_offset
    output logic [55:0]                     o_m_tdata,
    output logic [1:0]                      o_m_tuser,   // [1:0] kind
    output logic                            o_m_tlast,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlvd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tlvd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tlvd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [TYPE_COUNT-1:0] mask;
    logic                  s_accept;
    logic                  res_valid;
    logic                  ob_free;
    tlvd_pkg::t_result     res;
    tlvd_pkg::t_result     ob_res;

    tlvd_cfg #(
        .TYPE_COUNT (TYPE_COUNT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mask  (mask)
    );

    assign o_s_tready = ob_free;
    assign s_accept   = i_s_tvalid && ob_free;

    tlvd_parser #(
        .TYPE_COUNT (TYPE_COUNT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_accept),
        .i_byte      (i_s_tdata),
        .i_mask      (mask),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tlvd_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_accept && res_valid),
        .i_res    (res),
        .i_tready (i_m_tready),
        .o_tvalid (o_m_tvalid),
        .o_free   (ob_free),
        .o_res    (ob_res)
    );

    assign o_m_tdata = {ob_res.byte_offset, ob_res.byte_value,
                        ob_res.payload_length, ob_res.pkt_type};
    assign o_m_tuser = ob_res.kind;
    assign o_m_tlast = ob_res.last;

endmodule

FILE: rtl/tlvd_cfg.sv
// ----------------------------------------------------------------------------
// tlvd_cfg
// apb register block holding the accepted-types mask
// ----------------------------------------------------------------------------
module tlvd_cfg #(
    parameter int TYPE_COUNT = tlvd_pkg::TYPE_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlvd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlvd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlvd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [TYPE_COUNT-1:0]             o_mask
);

    logic [TYPE_COUNT-1:0] r_mask;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[3] == tlvd_pkg::REG_ACCEPT_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= TYPE_COUNT'(tlvd_pkg::RESET_MASK);
        end else if (wr_en) begin
            r_mask <= pwdata[TYPE_COUNT-1:0];
        end
    end

    always_comb begin
        unique case (paddr[3])
            tlvd_pkg::REG_ACCEPT_MASK: prdata = tlvd_pkg::APB_DATA_W'(r_mask);
            default:                   prdata = '0;
        endcase
    end

    assign o_mask = r_mask;

endmodule

FILE: rtl/tlvd_parser.sv
// ----------------------------------------------------------------------------
// tlvd_parser
// header collection, type check and payload counting, one byte per cycle while i_valid is high
// ----------------------------------------------------------------------------
module tlvd_parser #(
    parameter int TYPE_COUNT = tlvd_pkg::TYPE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic [TYPE_COUNT-1:0] i_mask,
    output logic                  o_res_valid,
    output tlvd_pkg::t_result     o_res
);

    localparam int IDX_W   = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int MASK_EX = 1 << IDX_W;

    tlvd_pkg::t_phase r_phase, n_phase;
    logic [23:0]      r_hdr, n_hdr;
    logic [15:0]      r_type, n_type;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_idx, n_idx;

    logic [15:0]        hdr_type;
    logic [15:0]        hdr_len;
    logic [MASK_EX-1:0] mask_ex;
    logic               type_ok;
    logic               pay_last;

    assign hdr_type = r_hdr[15:0];
    assign hdr_len  = {i_byte, r_hdr[23:16]};
    assign mask_ex  = MASK_EX'(i_mask);
    // types at or above the mask width are never selected
    assign type_ok  = (hdr_type < 16'(TYPE_COUNT)) && mask_ex[hdr_type[IDX_W-1:0]];
    assign pay_last = ({1'b0, r_idx} + 17'd1) == {1'b0, r_len};

    // next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            tlvd_pkg::PH_HDR0:    n_phase = tlvd_pkg::PH_HDR1;
            tlvd_pkg::PH_HDR1:    n_phase = tlvd_pkg::PH_HDR2;
            tlvd_pkg::PH_HDR2:    n_phase = tlvd_pkg::PH_HDR3;
            tlvd_pkg::PH_HDR3: begin
                if (!type_ok) begin
                    n_phase = tlvd_pkg::PH_ERROR;
                end else if (hdr_len == 16'd0) begin
                    n_phase = tlvd_pkg::PH_HDR0;
                end else begin
                    n_phase = tlvd_pkg::PH_PAYLOAD;
                end
            end
            tlvd_pkg::PH_PAYLOAD: n_phase = pay_last ? tlvd_pkg::PH_HDR0 : tlvd_pkg::PH_PAYLOAD;
            tlvd_pkg::PH_ERROR:   n_phase = tlvd_pkg::PH_ERROR;
            default:              n_phase = tlvd_pkg::PH_HDR1;
        endcase
    end

    // datapath and result
    always_comb begin
        n_hdr       = r_hdr;
        n_type      = r_type;
        n_len       = r_len;
        n_idx       = r_idx;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_phase)
            tlvd_pkg::PH_HDR0:    n_hdr = r_hdr | {16'd0, i_byte};
            tlvd_pkg::PH_HDR1:    n_hdr = r_hdr | {8'd0, i_byte, 8'd0};
            tlvd_pkg::PH_HDR2:    n_hdr = r_hdr | {i_byte, 16'd0};
            tlvd_pkg::PH_HDR3: begin
                n_hdr                = '0;
                n_type               = hdr_type;
                n_len                = hdr_len;
                n_idx                = '0;
                o_res_valid          = 1'b1;
                o_res.pkt_type       = hdr_type;
                o_res.payload_length = hdr_len;
                if (!type_ok) begin
                    o_res.kind = tlvd_pkg::KIND_ERROR;
                    o_res.last = 1'b1;
                end else begin
                    o_res.kind = tlvd_pkg::KIND_HEADER;
                    o_res.last = (hdr_len == 16'd0);
                end
            end
            tlvd_pkg::PH_PAYLOAD: begin
                n_idx                = pay_last ? 16'd0 : r_idx + 16'd1;
                o_res_valid          = 1'b1;
                o_res.kind           = tlvd_pkg::KIND_PAYLOAD;
                o_res.pkt_type       = r_type;
                o_res.payload_length = r_len;
                o_res.byte_value     = i_byte;
                o_res.byte_offset    = r_idx;
                o_res.last           = pay_last;
            end
            tlvd_pkg::PH_ERROR: begin
                o_res_valid = 1'b0;
            end
            // stray code restarts the header
            default:    n_hdr = {16'd0, i_byte};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlvd_pkg::PH_HDR0;
            r_hdr   <= '0;
            r_type  <= '0;
            r_len   <= '0;
            r_idx   <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_type  <= n_type;
            r_len   <= n_len;
            r_idx   <= n_idx;
        end
    end

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tlvd_pkg::PH_ERROR |=> r_phase == tlvd_pkg::PH_ERROR)
        else $error("error phase left without reset");

    a_result_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_phase == tlvd_pkg::PH_HDR3 || r_phase == tlvd_pkg::PH_PAYLOAD))
        else $error("result outside header end or payload");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tlvd_pkg::PH_PAYLOAD |-> r_idx < r_len)
        else $error("payload offset ran past length");

    a_hdr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tlvd_pkg::PH_HDR0 |-> r_hdr == 24'd0)
        else $error("header shift not cleared at packet start");

endmodule

FILE: rtl/tlvd_obuf.sv
// ----------------------------------------------------------------------------
// tlvd_obuf
// result register toward the master side
// ----------------------------------------------------------------------------
module tlvd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tlvd_pkg::t_result i_res,
    input  logic              i_tready,
    output logic              o_tvalid,
    output logic              o_free,
    output tlvd_pkg::t_result o_res
);

    logic              r_valid;
    tlvd_pkg::t_result r_res;

    // a waiting request may leave in the same cycle a new one enters
    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;

endmodule

FILE: test/tb_type_length_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_type_length_packet_deframer_core
// stream-level check of the type-length packet deframer against a local model
// ----------------------------------------------------------------------------
// A driver pushes bytes from a queue onto the slave side. A model of the
// deframer runs on every accepted byte and queues the result it should
// produce. A monitor compares each master-side result with that queue.
// The accept mask is rewritten over the APB port between phases. The only
// protocol error sits at the very end, because it holds until reset.
module tb_type_length_packet_deframer_core;

    localparam int LONG_HOLD = 300;

    logic                            i_clk;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [7:0]                      i_s_tdata  = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [55:0]                     o_m_tdata;
    logic [1:0]                      o_m_tuser;
    logic                            o_m_tlast;
    logic                            psel       = 1'b0;
    logic                            penable    = 1'b0;
    logic                            pwrite     = 1'b0;
    logic [tlvd_pkg::APB_ADDR_W-1:0] paddr      = '0;
    logic [tlvd_pkg::APB_DATA_W-1:0] pwdata     = '0;
    logic [tlvd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    type_length_packet_deframer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // stimulus bookkeeping
    logic [7:0] byte_queue[$];
    int         bytes_pushed = 0;
    int         bytes_taken  = 0;
    int         tx_gap       = 0;
    int         rx_gap       = 0;
    bit         calm         = 1'b0;
    logic       hold_go      = 1'b0;
    int         hold_cnt     = 0;

    // deframer model state
    tlvd_pkg::t_result expected_results[$];
    logic [63:0]       mask_model = tlvd_pkg::RESET_MASK;
    tlvd_pkg::t_phase  hdr_phase  = tlvd_pkg::PH_HDR0;
    logic [23:0]       hdr_bytes  = '0;
    logic [15:0]       cur_type   = '0;
    logic [15:0]       cur_len    = '0;
    logic [15:0]       pay_idx    = '0;
    bit                err_seen   = 1'b0;

    int                mismatches = 0;
    tlvd_pkg::t_result exp_r;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("Mismatches found");
        $finish;
    end

    task automatic deframe_byte(input logic [7:0] b);
        tlvd_pkg::t_result r;
        logic              accepted;
        if (err_seen) return;
        r = '0;
        if (hdr_phase == tlvd_pkg::PH_PAYLOAD) begin
            r.kind           = tlvd_pkg::KIND_PAYLOAD;
            r.pkt_type       = cur_type;
            r.payload_length = cur_len;
            r.byte_value     = b;
            r.byte_offset    = pay_idx;
            r.last           = (17'(pay_idx) + 17'd1 == 17'(cur_len));
            if (r.last) begin
                hdr_phase = tlvd_pkg::PH_HDR0;
                pay_idx   = '0;
            end else begin
                pay_idx = pay_idx + 16'd1;
            end
            expected_results.push_back(r);
        end else if (hdr_phase != tlvd_pkg::PH_HDR3) begin
            hdr_bytes = hdr_bytes | (24'(b) << (8 * hdr_phase));
            hdr_phase = tlvd_pkg::t_phase'(hdr_phase + 3'd1);
        end else begin
            // fourth header byte: latch header and run the type filter
            cur_type  = hdr_bytes[15:0];
            cur_len   = {b, hdr_bytes[23:16]};
            hdr_bytes = '0;
            pay_idx   = '0;
            accepted  = (cur_type < tlvd_pkg::TYPE_COUNT_DEF) && mask_model[cur_type[5:0]];
            r.pkt_type       = cur_type;
            r.payload_length = cur_len;
            if (!accepted) begin
                err_seen  = 1'b1;
                hdr_phase = tlvd_pkg::PH_HDR0;
                r.kind    = tlvd_pkg::KIND_ERROR;
                r.last    = 1'b1;
            end else begin
                r.kind    = tlvd_pkg::KIND_HEADER;
                r.last    = (cur_len == 16'd0);
                hdr_phase = r.last ? tlvd_pkg::PH_HDR0 : tlvd_pkg::PH_PAYLOAD;
            end
            expected_results.push_back(r);
        end
    endtask

    // slave-side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                deframe_byte(i_s_tdata);
                bytes_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= byte_queue.pop_front();
                    if (!calm && $urandom_range(0, 11) == 0)
                        tx_gap = $urandom_range(1, 14);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // master-side ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_go && hold_cnt < LONG_HOLD) begin
            hold_cnt++;
            i_m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
                rx_gap = $urandom_range(1, 14);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d type %h len %h byte %h off %h last %b",
                             o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16],
                             o_m_tdata[39:32], o_m_tdata[55:40], o_m_tlast);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_m_tuser != exp_r.kind || o_m_tdata[15:0] != exp_r.pkt_type ||
                    o_m_tdata[31:16] != exp_r.payload_length ||
                    o_m_tdata[39:32] != exp_r.byte_value ||
                    o_m_tdata[55:40] != exp_r.byte_offset || o_m_tlast != exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("expected: kind %0d type %h len %h byte %h off %h last %b",
                                 exp_r.kind, exp_r.pkt_type, exp_r.payload_length,
                                 exp_r.byte_value, exp_r.byte_offset, exp_r.last);
                        $display("actual:   kind %0d type %h len %h byte %h off %h last %b",
                                 o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16],
                                 o_m_tdata[39:32], o_m_tdata[55:40], o_m_tlast);
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_pushed++;
    endtask

    task automatic push_header(input logic [15:0] ptype, input logic [15:0] plen);
        push_byte(ptype[7:0]);
        push_byte(ptype[15:8]);
        push_byte(plen[7:0]);
        push_byte(plen[15:8]);
    endtask

    task automatic wait_idle();
        while (bytes_taken != bytes_pushed || expected_results.size() != 0)
            @(posedge i_clk);
        // header bytes give no result, so allow them to settle
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [63:0] m);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {tlvd_pkg::REG_ACCEPT_MASK, 3'b000};
        pwdata  <= m;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        mask_model = m;
    endtask

    initial begin : stimulus
        logic [63:0] m;
        logic [15:0] ptype;
        int          len;
        int          r;
        int          phase_bytes;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset mask, empty packet and payload extremes
        push_header(16'd0, 16'd0);
        push_header(16'd1, 16'd2);
        push_byte(8'h00);
        push_byte(8'hFF);
        wait_idle();

        write_mask('1);
        push_header(16'd63, 16'd1);
        push_byte(8'h80);
        wait_idle();

        write_mask(64'h8000_0000_0000_0000);
        push_header(16'd63, 16'd0);
        // mask changes between the third and fourth header bytes
        push_header(16'd5, 16'd1);
        byte_queue.pop_back();
        bytes_pushed--;
        wait_idle();
        write_mask(64'h0000_0000_0000_0020);
        push_byte(8'h00);
        push_byte(8'h7F);
        wait_idle();

        // random phases of well-formed packets
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 1)
                m = '1;
            else if (ph == 4)
                m = tlvd_pkg::RESET_MASK;
            else if (ph == 6)
                m = 64'd1 << $urandom_range(0, 63);
            else
                m = {$urandom, $urandom} | (64'd1 << $urandom_range(0, 63));
            write_mask(m);
            if (ph == 2) begin
                @(posedge i_clk);
                hold_go <= 1'b1;
            end
            if (ph == 5)
                calm = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < 140) begin
                ptype = 16'($urandom_range(0, 63));
                while (!m[ptype[5:0]])
                    ptype = 16'((ptype + 1) % 64);
                r = $urandom_range(0, 99);
                if (r < 80)
                    len = $urandom_range(0, 12);
                else if (r < 95)
                    len = $urandom_range(13, 64);
                else
                    len = $urandom_range(65, 300);
                push_header(ptype, 16'(len));
                for (int k = 0; k < len; k++)
                    push_byte(8'($urandom));
                phase_bytes += len + 4;
            end
            wait_idle();
        end

        // the one protocol error: out-of-range type or unselected type
        if ($urandom_range(0, 1) == 1) begin
            write_mask('1);
            push_header(16'($urandom_range(tlvd_pkg::TYPE_COUNT_DEF, 65535)), 16'($urandom));
        end else begin
            write_mask('0);
            push_header(16'($urandom_range(0, 63)), 16'($urandom));
        end
        // dropped after the error
        for (int k = 0; k < 16; k++)
            push_byte(8'($urandom));
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/tlvd_pkg.sv
rtl/tlvd_cfg.sv
rtl/tlvd_parser.sv
rtl/tlvd_obuf.sv
rtl/type_length_packet_deframer_core.sv
test/tb_type_length_packet_deframer_core.sv
